// File: sv/bbz_pkg.sv
// ----------------------------------------------------------------------------
// bbz_pkg
// Shared payload types and register indexes of the zero padded box blur.
// ----------------------------------------------------------------------------
`default_nettype none

package bbz_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_BLUR_RADIUS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } bbz_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_last;
  } bbz_out_t;

endpackage

`default_nettype wire

// File: sv/bbz_fifo.sv
// ----------------------------------------------------------------------------
// bbz_fifo
// Two-entry queue of window jobs between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module bbz_fifo #(
  parameter int DW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire logic [DW-1:0] push_data,
  output logic               full,
  input  wire logic          pop,
  output logic [DW-1:0]      pop_data,
  output logic               empty
);

  logic [DW-1:0] ent0_r, ent1_r;
  logic [1:0]    cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = ent0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (push && cnt_r == 2'd1) begin
        ent0_r <= push_data;
      end else begin
        ent0_r <= ent1_r;
      end
      if (push && cnt_r == 2'd2) begin
        ent1_r <= push_data;
      end
    end else if (push) begin
      if (cnt_r == 2'd0) begin
        ent0_r <= push_data;
      end else begin
        ent1_r <= push_data;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/bbz_front.sv
// ----------------------------------------------------------------------------
// bbz_front
// Accepts stream items, writes the line store and issues window jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module bbz_front
  import bbz_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_RADIUS = 15
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic restart,
  input  wire logic [$clog2(MAX_RADIUS+1)-1:0] eff_r,
  input  wire logic [$clog2(MAX_WIDTH+1)-1:0]  eff_w,
  input  wire logic [$clog2(MAX_HEIGHT+1)-1:0] eff_h,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire bbz_in_t in_data,
  output logic         wr_en,
  output logic [$clog2(2*MAX_RADIUS*MAX_WIDTH+2*MAX_RADIUS+9)-1:0] wr_addr,
  output logic [23:0]  wr_data,
  output logic         job_push,
  output logic [1+$clog2(MAX_HEIGHT+1)+$clog2(MAX_WIDTH+1)
                +$clog2(2*MAX_RADIUS*MAX_WIDTH+2*MAX_RADIUS+9)-1:0] job_data,
  input  wire logic    job_full,
  input  wire logic    frame_done
);

  localparam int WW = $clog2(MAX_WIDTH+1);
  localparam int HW = $clog2(MAX_HEIGHT+1);
  localparam int AW = $clog2(2*MAX_RADIUS*MAX_WIDTH+2*MAX_RADIUS+9);
  localparam int PW = $clog2(MAX_WIDTH*MAX_HEIGHT+MAX_RADIUS*MAX_WIDTH+MAX_RADIUS+1);

  typedef struct packed {
    logic          last;
    logic [HW-1:0] oy;
    logic [WW-1:0] ox;
    logic [AW-1:0] base;
  } job_t;

  logic [PW-1:0] p_r;
  logic [HW-1:0] oy_r;
  logic [WW-1:0] ox_r;
  logic          drain_r;

  logic [PW-1:0] delay, total, q;
  logic          acc, emit, last;
  job_t          job;

  assign delay = PW'(eff_r * eff_w) + PW'(eff_r);
  assign total = PW'(eff_w * eff_h);
  assign q     = p_r - delay;

  assign in_stall = drain_r || job_full;
  assign acc      = in_valid && !in_stall;
  assign emit     = (p_r >= delay);
  assign last     = emit && (q == total - PW'(1));

  assign wr_en   = acc;
  assign wr_addr = p_r[AW-1:0];
  assign wr_data = (in_data.command == CMD_PIXEL && p_r < total) ?
                   {in_data.red_in, in_data.green_in, in_data.blue_in} : 24'd0;

  assign job.last = last;
  assign job.oy   = oy_r;
  assign job.ox   = ox_r;
  assign job.base = p_r[AW-1:0] - delay[AW-1:0] - delay[AW-1:0];

  assign job_push = acc && emit;
  assign job_data = job;

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      p_r     <= '0;
      oy_r    <= '0;
      ox_r    <= '0;
      drain_r <= 1'b0;
    end else begin
      if (frame_done) begin
        drain_r <= 1'b0;
      end
      if (acc) begin
        if (last) begin
          p_r     <= '0;
          oy_r    <= '0;
          ox_r    <= '0;
          drain_r <= 1'b1;
        end else begin
          p_r <= p_r + PW'(1);
          if (emit) begin
            if (ox_r == eff_w - WW'(1)) begin
              ox_r <= '0;
              oy_r <= oy_r + HW'(1);
            end else begin
              ox_r <= ox_r + WW'(1);
            end
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/bbz_back.sv
// ----------------------------------------------------------------------------
// bbz_back
// Holds the line store, sums one window per job and divides by its area.
// ----------------------------------------------------------------------------
`default_nettype none

module bbz_back
  import bbz_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_RADIUS = 15
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic [$clog2(MAX_RADIUS+1)-1:0] eff_r,
  input  wire logic [$clog2(MAX_WIDTH+1)-1:0]  eff_w,
  input  wire logic [$clog2(MAX_HEIGHT+1)-1:0] eff_h,
  input  wire logic    wr_en,
  input  wire logic [$clog2(2*MAX_RADIUS*MAX_WIDTH+2*MAX_RADIUS+9)-1:0] wr_addr,
  input  wire logic [23:0] wr_data,
  input  wire logic    job_empty,
  input  wire logic [1+$clog2(MAX_HEIGHT+1)+$clog2(MAX_WIDTH+1)
                     +$clog2(2*MAX_RADIUS*MAX_WIDTH+2*MAX_RADIUS+9)-1:0] job_data,
  output logic         job_pop,
  output logic         out_valid,
  input  wire logic    out_stall,
  output bbz_out_t     out_data,
  output logic         frame_done
);

  localparam int WW = $clog2(MAX_WIDTH+1);
  localparam int HW = $clog2(MAX_HEIGHT+1);
  localparam int AW = $clog2(2*MAX_RADIUS*MAX_WIDTH+2*MAX_RADIUS+9);
  localparam int DW = $clog2(2*MAX_RADIUS+1);
  localparam int CW = ((WW > HW) ? WW : HW) + 2;
  localparam int AR = $clog2((2*MAX_RADIUS+1)*(2*MAX_RADIUS+1)+1);
  localparam int SW = $clog2((2*MAX_RADIUS+1)*(2*MAX_RADIUS+1)*255+1);
  localparam int KW = $clog2(SW+1);

  typedef struct packed {
    logic          last;
    logic [HW-1:0] oy;
    logic [WW-1:0] ox;
    logic [AW-1:0] base;
  } job_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_DRAIN = 5'b00100,
    S_DIV   = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  logic [23:0] mem [2**AW];
  logic [23:0] mem_q_r;

  state_t        state_r, state_nxt;
  job_t          job_r, job_in;
  logic [AW-1:0] addr_r;
  logic [DW-1:0] dx_r, dy_r;
  logic          rd_vld_r;
  logic [KW-1:0] cnt_r;
  logic [SW-1:0] acc_r [3];
  logic [AR-1:0] rem_r [3];

  logic [DW-1:0]        two_r;
  logic [AR-1:0]        area;
  logic signed [CW-1:0] ys, xs;
  logic                 inb, rd_en, step_last;
  logic [AR:0]          trial [3];
  logic                 qbit [3];
  logic [7:0]           byte_q [3];

  assign job_in = job_data;
  assign two_r  = {eff_r, 1'b0};
  assign area   = AR'((2 * eff_r + 1) * (2 * eff_r + 1));

  assign ys = $signed(CW'(job_r.oy)) - $signed(CW'(eff_r)) + $signed(CW'(dy_r));
  assign xs = $signed(CW'(job_r.ox)) - $signed(CW'(eff_r)) + $signed(CW'(dx_r));
  assign inb = !ys[CW-1] && !xs[CW-1] &&
               (ys < $signed(CW'(eff_h))) && (xs < $signed(CW'(eff_w)));

  assign rd_en     = (state_r == S_READ) && inb;
  assign step_last = (dx_r == two_r) && (dy_r == two_r);

  assign byte_q[0] = mem_q_r[23:16];
  assign byte_q[1] = mem_q_r[15:8];
  assign byte_q[2] = mem_q_r[7:0];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      trial[c] = {rem_r[c], acc_r[c][SW-1]};
      qbit[c]  = (trial[c] >= {1'b0, area});
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q_r <= mem[addr_r];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (!job_empty) state_nxt = S_READ;
      S_READ:  if (step_last) state_nxt = S_DRAIN;
      S_DRAIN: state_nxt = S_DIV;
      S_DIV:   if (cnt_r == KW'(SW - 1)) state_nxt = S_OUT;
      S_OUT:   if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        job_r  <= job_in;
        addr_r <= job_in.base;
        dx_r   <= '0;
        dy_r   <= '0;
        for (int c = 0; c < 3; c++) begin
          acc_r[c] <= '0;
        end
      end
      S_READ: begin
        if (dx_r == two_r) begin
          dx_r   <= '0;
          dy_r   <= dy_r + DW'(1);
          addr_r <= addr_r + AW'(eff_w) - AW'(two_r);
        end else begin
          dx_r   <= dx_r + DW'(1);
          addr_r <= addr_r + AW'(1);
        end
      end
      S_DRAIN: begin
        cnt_r <= '0;
        for (int c = 0; c < 3; c++) begin
          rem_r[c] <= '0;
        end
      end
      S_DIV: begin
        cnt_r <= cnt_r + KW'(1);
        for (int c = 0; c < 3; c++) begin
          rem_r[c] <= qbit[c] ? AR'(trial[c] - {1'b0, area}) : trial[c][AR-1:0];
          acc_r[c] <= {acc_r[c][SW-2:0], qbit[c]};
        end
      end
      default: begin
      end
    endcase
    if (rd_vld_r) begin
      for (int c = 0; c < 3; c++) begin
        acc_r[c] <= acc_r[c] + SW'(byte_q[c]);
      end
    end
  end

  assign job_pop   = (state_r == S_IDLE) && !job_empty;
  assign out_valid = (state_r == S_OUT);

  assign out_data.red_out    = acc_r[0][7:0];
  assign out_data.green_out  = acc_r[1][7:0];
  assign out_data.blue_out   = acc_r[2][7:0];
  assign out_data.frame_last = job_r.last;

  assign frame_done = out_valid && !out_stall && job_r.last;

endmodule

`default_nettype wire

// File: sv/box_blur_zero_padded_core.sv
// ----------------------------------------------------------------------------
// box_blur_zero_padded_core
// Zero padded RGB box blur over a raster stream with configurable radius.
// ----------------------------------------------------------------------------
//  channel  | ports                          | moves
//  input    | in_valid / in_stall / in_data  | pixel or flush transaction
//  result   | out_valid / out_stall / out_data | blurred pixel transaction
//  config   | cfg_we / cfg_index / cfg_data  | register write, no wait
//
//  Items are taken one per cycle until the two-entry job queue fills.
//  Each result walks the single read port of the line store once per window
//  element, then runs an 18-step restoring divider, one per channel, with the
//  three channels side by side; an output stall holds the result.
//  Reset needs no clearing pass; after the marked last result of a frame
//  input stalls until that result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module box_blur_zero_padded_core
  import bbz_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_RADIUS = 15
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire bbz_in_t               in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output bbz_out_t                   out_data
);

  localparam int RW = $clog2(MAX_RADIUS+1);
  localparam int WW = $clog2(MAX_WIDTH+1);
  localparam int HW = $clog2(MAX_HEIGHT+1);
  localparam int AW = $clog2(2*MAX_RADIUS*MAX_WIDTH+2*MAX_RADIUS+9);
  localparam int JW = 1 + HW + WW + AW;

  logic [3:0]  radius_r;
  logic [10:0] width_r, height_r;

  logic [RW-1:0] eff_r;
  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;
  logic          restart;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [23:0]   wr_data;
  logic          job_push, job_pop, job_full, job_empty, frame_done;
  logic [JW-1:0] job_wdata, job_rdata;

  assign restart = cfg_we && (cfg_index == CFG_BLUR_RADIUS ||
                              cfg_index == CFG_FRAME_WIDTH ||
                              cfg_index == CFG_FRAME_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= 4'd0;
      width_r  <= 11'd1024;
      height_r <= 11'd1024;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BLUR_RADIUS:  radius_r <= cfg_data[3:0];
        CFG_FRAME_WIDTH:  width_r  <= cfg_data;
        CFG_FRAME_HEIGHT: height_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign eff_r = (32'(radius_r) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(radius_r);
  assign eff_w = (width_r == 11'd0) ? WW'(1) :
                 (32'(width_r) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(width_r);
  assign eff_h = (height_r == 11'd0) ? HW'(1) :
                 (32'(height_r) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(height_r);

  bbz_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_RADIUS(MAX_RADIUS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .restart   (restart),
    .eff_r     (eff_r),
    .eff_w     (eff_w),
    .eff_h     (eff_h),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .job_push  (job_push),
    .job_data  (job_wdata),
    .job_full  (job_full),
    .frame_done(frame_done)
  );

  bbz_fifo #(
    .DW(JW)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_data(job_wdata),
    .full     (job_full),
    .pop      (job_pop),
    .pop_data (job_rdata),
    .empty    (job_empty)
  );

  bbz_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_RADIUS(MAX_RADIUS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .eff_r     (eff_r),
    .eff_w     (eff_w),
    .eff_h     (eff_h),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .job_empty (job_empty),
    .job_data  (job_rdata),
    .job_pop   (job_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .frame_done(frame_done)
  );

endmodule

`default_nettype wire
